// File: src/opht_pkg.sv
// ----------------------------------------------------------------------------
// opht_pkg
// Shared constants, op codes and the queue item type of the ordered-probe
// hash table.
// ----------------------------------------------------------------------------
package opht_pkg;

	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int N_W      = SLOT_W + 1;
	localparam int KEY_W    = 64;
	localparam int ACT_W    = 2;
	localparam int HOPS_W   = 12;
	localparam int CFG_W    = 11;
	localparam int WORD_W   = SLOT_W + KEY_W;

	localparam logic [ACT_W-1:0] OP_QUERY  = 2'd0;
	localparam logic [ACT_W-1:0] OP_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] OP_DELETE = 2'd2;
	localparam logic [ACT_W-1:0] OP_NOP    = 2'd3;

	localparam logic [KEY_W-1:0] MURMUR_M  = 64'hc6a4a7935bd1e995;
	localparam logic [KEY_W-1:0] MURMUR_M8 = MURMUR_M << 3;
	localparam int               MURMUR_R  = 47;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [ACT_W-1:0]  op;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] home;
	} item_t;

endpackage

// File: src/ordered_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// ordered_probe_hash_table_core
// Ordered-probe hash table with a 64-bit key store, hashing front end,
// item queue and slot-by-slot table engine.
// ----------------------------------------------------------------------------
// Usage: items (action, key) enter on the in_valid/in_ready channel, one
// result beat (found, hops) leaves on out_valid/out_ready per item, in order.
// table_size is written over the APB-style port at byte address 0; write it
// only while the block is idle, which the block itself leaves to the user.
// pready is always high. After reset the slot memory is cleared, one slot a
// cycle: in_ready stays low during the clearing pass while configuration
// writes are still taken. Front: accept, four 64-bit multiplies on one
// 32x32 multiplier, a bit-serial remainder, push; the front takes no new
// item until it has pushed the last.
// Back: setup (start pointer reduction), then a read state and an evaluate
// state per slot visited on the single memory read port, plus closing write
// states; reserved keys and NOP actions go straight to the result beat.
// Front and back overlap through a 2-entry queue. A stalled receiver holds
// the result beat in its register; the engine stops after its next item and
// the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module ordered_probe_hash_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [opht_pkg::ACT_W-1:0]  action,
	input  logic [opht_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [opht_pkg::HOPS_W-1:0] hops
);
	import opht_pkg::*;

	localparam logic REG_TABLE_SIZE = 1'b0;

	logic [CFG_W-1:0] table_size_q;
	logic [N_W-1:0]   n;
	logic             cfg_wr;
	logic             hold;
	logic             push_valid;
	logic             push_ready;
	item_t            push_item;
	logic             pop_valid;
	logic             pop_ready;
	item_t            pop_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(table_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= CFG_W'(CAPACITY);
		end else if (cfg_wr && paddr[2] == REG_TABLE_SIZE) begin
			table_size_q <= pwdata[CFG_W-1:0];
		end
	end

	// slots in use, clamped to 1..CAPACITY
	always_comb begin
		if (table_size_q == '0) begin
			n = N_W'(1);
		end else if (32'(table_size_q) > 32'(CAPACITY)) begin
			n = N_W'(CAPACITY);
		end else begin
			n = N_W'(table_size_q);
		end
	end

	opht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.key        (key),
		.hold       (hold),
		.n          (n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	opht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	opht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.clearing  (hold),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.hops      (hops)
	);

endmodule

// File: src/opht_ram.sv
// ----------------------------------------------------------------------------
// opht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/opht_front.sv
// ----------------------------------------------------------------------------
// opht_front
// Accepts items, screens reserved keys and NOP actions, hashes the key
// and reduces the hash modulo the table size to the home slot.
// ----------------------------------------------------------------------------
module opht_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [opht_pkg::ACT_W-1:0] action,
	input  logic [opht_pkg::KEY_W-1:0] key,
	input  logic                       hold,
	input  logic [opht_pkg::N_W-1:0]   n,
	output logic                       push_valid,
	output opht_pkg::item_t            push_item,
	input  logic                       push_ready
);
	import opht_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_MOD  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	localparam logic [1:0] PH_LL   = 2'd0;
	localparam logic [1:0] PH_LH   = 2'd1;
	localparam logic [1:0] PH_HL   = 2'd2;
	localparam logic [1:0] PH_POST = 2'd3;

	localparam logic [1:0] MS_KEY  = 2'd0;
	localparam logic [1:0] MS_K    = 2'd1;
	localparam logic [1:0] MS_H1   = 2'd2;
	localparam logic [1:0] MS_H2   = 2'd3;

	localparam int CNT_W = $clog2(KEY_W);

	logic [1:0]       state_q;
	logic [1:0]       ph_q;
	logic [1:0]       ms_q;
	logic [KEY_W-1:0] a_q;
	logic [KEY_W-1:0] acc_q;
	logic [KEY_W-1:0] div_q;
	logic [N_W-1:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	item_t            item_q;

	logic [31:0]      opa;
	logic [31:0]      opb;
	logic [63:0]      prod;
	logic [KEY_W-1:0] xs;
	logic [N_W:0]     trial;
	logic [N_W:0]     diff;
	logic [N_W-1:0]   rem_next;
	logic             reserved;

	assign in_ready   = (state_q == F_IDLE) && !hold;
	assign push_valid = (state_q == F_PUSH);
	assign push_item  = item_q;
	assign reserved   = (key == '0) || (key == '1);

	// one 32x32 partial product per phase, low 64 bits of a * M
	assign opa  = (ph_q == PH_HL) ? a_q[63:32] : a_q[31:0];
	assign opb  = (ph_q == PH_LH) ? MURMUR_M[63:32] : MURMUR_M[31:0];
	assign prod = opa * opb;
	assign xs   = acc_q ^ (acc_q >> MURMUR_R);

	// restoring remainder, one dividend bit a step
	assign trial    = {rem_q, div_q[KEY_W-1]};
	assign diff     = trial - {1'b0, n};
	assign rem_next = (trial >= {1'b0, n}) ? diff[N_W-1:0] : trial[N_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ph_q    <= PH_LL;
			ms_q    <= MS_KEY;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid && in_ready) begin
						item_q.key  <= key;
						item_q.home <= '0;
						a_q         <= key;
						ph_q        <= PH_LL;
						ms_q        <= MS_KEY;
						if (reserved || action == OP_NOP) begin
							item_q.op <= OP_NOP;
							state_q   <= F_PUSH;
						end else begin
							item_q.op <= action;
							state_q   <= F_MUL;
						end
					end
				end
				F_MUL: begin
					ph_q <= ph_q + 2'd1;
					case (ph_q)
						PH_LL:   acc_q <= prod;
						PH_LH,
						PH_HL:   acc_q <= acc_q + {prod[31:0], 32'h0};
						default: begin
							ms_q <= ms_q + 2'd1;
							case (ms_q)
								MS_KEY:  a_q <= xs;
								MS_K:    a_q <= MURMUR_M8 ^ acc_q;
								MS_H1:   a_q <= xs;
								default: begin
									div_q   <= xs;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= F_MOD;
								end
							endcase
						end
					endcase
				end
				F_MOD: begin
					rem_q <= rem_next;
					div_q <= {div_q[KEY_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(KEY_W - 1)) begin
						item_q.home <= rem_next[SLOT_W-1:0];
						state_q     <= F_PUSH;
					end
				end
				default: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// File: src/opht_queue.sv
// ----------------------------------------------------------------------------
// opht_queue
// Short FIFO of classified items between the hashing front and the table
// engine.
// ----------------------------------------------------------------------------
module opht_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  opht_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output opht_pkg::item_t pop_item
);
	import opht_pkg::*;

	item_t              ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q < Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/opht_back.sv
// ----------------------------------------------------------------------------
// opht_back
// Table engine: clears the slot memory after reset, then runs query, insert
// and delete probes one slot at a time and holds the result beat.
// ----------------------------------------------------------------------------
module opht_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [opht_pkg::N_W-1:0]    n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  opht_pkg::item_t             pop_item,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [opht_pkg::HOPS_W-1:0] hops
);
	import opht_pkg::*;

	localparam int BS_W = 5;
	localparam logic [BS_W-1:0] B_CLR    = 5'd0;
	localparam logic [BS_W-1:0] B_IDLE   = 5'd1;
	localparam logic [BS_W-1:0] B_RED    = 5'd2;
	localparam logic [BS_W-1:0] B_LAUNCH = 5'd3;
	localparam logic [BS_W-1:0] B_Q_RD   = 5'd4;
	localparam logic [BS_W-1:0] B_Q_EV   = 5'd5;
	localparam logic [BS_W-1:0] B_I_RD   = 5'd6;
	localparam logic [BS_W-1:0] B_I_EV   = 5'd7;
	localparam logic [BS_W-1:0] B_I_W2   = 5'd8;
	localparam logic [BS_W-1:0] B_R_RD   = 5'd9;
	localparam logic [BS_W-1:0] B_R_EV   = 5'd10;
	localparam logic [BS_W-1:0] B_F_W1   = 5'd11;
	localparam logic [BS_W-1:0] B_F_W2   = 5'd12;
	localparam logic [BS_W-1:0] B_D_RD   = 5'd13;
	localparam logic [BS_W-1:0] B_D_EV   = 5'd14;
	localparam logic [BS_W-1:0] B_S_RD   = 5'd15;
	localparam logic [BS_W-1:0] B_S_EV   = 5'd16;
	localparam logic [BS_W-1:0] B_S_Z    = 5'd17;
	localparam logic [BS_W-1:0] B_DONE   = 5'd18;

	localparam int              RED_W    = $clog2(SLOT_W + 1);
	localparam logic [RED_W-1:0] RED_LAST = RED_W'(SLOT_W - 1);
	localparam int              SH_W     = SLOT_W + N_W;

	logic [BS_W-1:0]   state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] start_q;
	logic [SLOT_W-1:0] st_q;
	logic [RED_W-1:0]  red_q;
	logic [ACT_W-1:0]  op_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] home_q;
	logic [SLOT_W-1:0] i_q;
	logic [SLOT_W-1:0] ind_q;
	logic              carry_q;
	logic              first_q;
	logic [KEY_W-1:0]  tk_q;
	logic [SLOT_W-1:0] th_q;
	logic [KEY_W-1:0]  rk_q;
	logic [SLOT_W-1:0] rh_q;
	logic              found_q;
	logic [HOPS_W-1:0] hops_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [HOPS_W-1:0] out_hops_q;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [KEY_W-1:0]  rd_key;
	logic [SLOT_W-1:0] rd_home;
	logic [KEY_W-1:0]  erk;
	logic [SLOT_W-1:0] erh;
	logic [SLOT_W-1:0] ni;
	logic [SLOT_W-1:0] nst;
	logic [SLOT_W-1:0] i_inc;
	logic [SLOT_W-1:0] i_start;
	logic              home_lt_st;
	logic [HOPS_W-1:0] hops_inc;
	logic [SH_W-1:0]   nsh;
	logic              out_load;

	function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] i,
		input logic [N_W-1:0] nn);
		logic [N_W-1:0] ip;
		ip = N_W'(i) + N_W'(1);
		return (ip >= nn) ? '0 : ip[SLOT_W-1:0];
	endfunction

	opht_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (i_q),
		.rdata (ram_rdata)
	);

	assign rd_key     = ram_rdata[KEY_W-1:0];
	assign rd_home    = ram_rdata[WORD_W-1:KEY_W];
	assign erk        = first_q ? rd_key : rk_q;
	assign erh        = first_q ? rd_home : rh_q;
	assign ni         = nxt(i_q, n);
	assign nst        = nxt(st_q, n);
	assign i_inc      = i_q + 1'b1;
	assign home_lt_st = (home_q < st_q);
	assign i_start    = home_lt_st ? st_q : home_q;
	assign hops_inc   = (hops_q == '1) ? hops_q : hops_q + 1'b1;
	assign nsh        = SH_W'(n) << red_q;
	assign out_load   = (state_q == B_DONE) && (!out_valid_q || out_ready);

	assign pop_ready = (state_q == B_IDLE);
	assign clearing  = (state_q == B_CLR);
	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign hops      = out_hops_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = '0;
		case (state_q)
			B_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			B_I_EV: begin
				if (rd_key == '0) begin
					ram_we    = 1'b1;
					ram_wdata = carry_q ? {th_q, tk_q} : {home_q, key_q};
				end else if (carry_q && rd_home != th_q) begin
					ram_we    = 1'b1;
					ram_wdata = {th_q, tk_q};
				end
			end
			B_I_W2, B_F_W2: begin
				ram_we    = 1'b1;
				ram_waddr = ind_q;
				ram_wdata = {home_q, key_q};
			end
			B_R_EV: begin
				if (rd_key == '0 || rd_home != erh) begin
					ram_we    = 1'b1;
					ram_wdata = {erh, erk};
				end
			end
			B_F_W1: begin
				ram_we    = 1'b1;
				ram_waddr = st_q;
				ram_wdata = carry_q ? {th_q, tk_q} : {home_q, key_q};
			end
			B_S_EV: begin
				// pull the entry back one slot, or close the gap
				ram_we    = 1'b1;
				ram_waddr = ind_q;
				ram_wdata = (rd_home == i_q) ? '0 : ram_rdata;
			end
			B_S_Z: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			start_q     <= '0;
			red_q       <= '0;
			carry_q     <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(CAPACITY - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						op_q    <= pop_item.op;
						key_q   <= pop_item.key;
						home_q  <= pop_item.home;
						found_q <= 1'b0;
						hops_q  <= '0;
						st_q    <= start_q;
						red_q   <= RED_LAST;
						state_q <= (pop_item.op == OP_NOP) ? B_DONE : B_RED;
					end
				end
				B_RED: begin
					// start pointer modulo n, one quotient bit a cycle
					if (SH_W'(st_q) >= nsh) begin
						st_q <= st_q - nsh[SLOT_W-1:0];
					end
					red_q <= red_q - 1'b1;
					if (red_q == '0) begin
						state_q <= B_LAUNCH;
					end
				end
				B_LAUNCH: begin
					i_q     <= i_start;
					carry_q <= 1'b0;
					case (op_q)
						OP_QUERY:  state_q <= B_Q_RD;
						OP_INSERT: state_q <= B_I_RD;
						OP_DELETE: state_q <= B_D_RD;
						default:   state_q <= B_DONE;
					endcase
				end
				B_Q_RD: state_q <= B_Q_EV;
				B_Q_EV: begin
					if (rd_key == key_q) begin
						found_q <= 1'b1;
						state_q <= B_DONE;
					end else if (rd_key == '0 || rd_home > home_q || ni == st_q) begin
						state_q <= B_DONE;
					end else begin
						i_q     <= ni;
						state_q <= B_Q_RD;
					end
				end
				B_I_RD: state_q <= B_I_EV;
				B_I_EV: begin
					hops_q <= hops_inc;
					if (rd_key == '0) begin
						state_q <= carry_q ? B_I_W2 : B_DONE;
					end else begin
						if (!carry_q && rd_home > home_q) begin
							ind_q   <= i_q;
							carry_q <= 1'b1;
							tk_q    <= rd_key;
							th_q    <= rd_home;
						end else if (carry_q && rd_home != th_q) begin
							tk_q <= rd_key;
							th_q <= rd_home;
						end
						if (ni == st_q) begin
							if (home_lt_st) begin
								state_q <= B_DONE;
							end else begin
								// table full: ripple start..home, then rotate start
								i_q     <= st_q;
								first_q <= 1'b1;
								state_q <= (st_q == home_q) ? B_F_W1 : B_R_RD;
							end
						end else begin
							i_q     <= ni;
							state_q <= B_I_RD;
						end
					end
				end
				B_I_W2: state_q <= B_DONE;
				B_R_RD: state_q <= B_R_EV;
				B_R_EV: begin
					hops_q  <= hops_inc;
					first_q <= 1'b0;
					if (rd_key == '0) begin
						state_q <= B_F_W1;
					end else begin
						if (rd_home != erh) begin
							rk_q <= rd_key;
							rh_q <= rd_home;
						end else begin
							rk_q <= erk;
							rh_q <= erh;
						end
						i_q     <= i_inc;
						state_q <= (i_inc == home_q) ? B_F_W1 : B_R_RD;
					end
				end
				B_F_W1: begin
					start_q <= nst;
					state_q <= carry_q ? B_F_W2 : B_DONE;
				end
				B_F_W2: state_q <= B_DONE;
				B_D_RD: state_q <= B_D_EV;
				B_D_EV: begin
					if (rd_key == key_q) begin
						ind_q   <= i_q;
						i_q     <= ni;
						state_q <= B_S_RD;
					end else if (rd_key == '0 || rd_home > home_q || ni == st_q) begin
						state_q <= B_DONE;
					end else begin
						i_q     <= ni;
						state_q <= B_D_RD;
					end
				end
				B_S_RD: state_q <= B_S_EV;
				B_S_EV: begin
					if (rd_home == i_q) begin
						state_q <= B_DONE;
					end else if (ni == st_q) begin
						state_q <= B_S_Z;
					end else begin
						ind_q   <= i_q;
						i_q     <= ni;
						state_q <= B_S_RD;
					end
				end
				B_S_Z: state_q <= B_DONE;
				B_DONE: begin
					if (out_load) begin
						out_found_q <= found_q;
						out_hops_q  <= hops_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLR) |-> (ram_we && ram_wdata == '0))
		else $error("clearing pass must write empty slots");

	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_F_W1) |=> (N_W'(start_q) < n))
		else $error("rotated start pointer out of range");

	a_hops_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE && op_q != OP_INSERT) |-> (hops_q == '0))
		else $error("hop count set by a non-insert action");

	a_found_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE && found_q) |-> (op_q == OP_QUERY))
		else $error("found set by a non-query action");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop_ready)
		else $error("item taken during clearing pass");

endmodule
